// ===== hdl/radio_control_frame_parser_top_defines.svh =====
// Assertion macros shared by the frame parser RTL.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef RADIO_CONTROL_FRAME_PARSER_TOP_DEFINES_SVH
`define RADIO_CONTROL_FRAME_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RCFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rcfp assertion failed");
`define RCFP_NEVER(lbl, clk, rst_n, expr) `RCFP_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define RCFP_ASSERT(lbl, clk, rst_n, prop)
`define RCFP_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/rcfp_pkg.sv =====
// Types, constants and the CRC-8 step for the radio control frame parser.
// No dependencies; used by rcfp_emit and radio_control_frame_parser_top.
package rcfp_pkg;

    localparam logic [7:0] SYNC_RESET    = 8'hC8;
    localparam logic [5:0] MAXLEN_RESET  = 6'd62;
    localparam logic [7:0] TYPE_CHANNELS = 8'h16;
    localparam logic [7:0] TYPE_LINK     = 8'h14;
    localparam logic [7:0] TYPE_ATTITUDE = 8'h1E;
    localparam logic [7:0] CRC_POLY      = 8'hD5;
    localparam logic [5:0] ATT_LEN       = 6'd8;

    localparam int CHANNEL_COUNT = 16;
    localparam int LINK_COUNT    = 10;
    localparam int ATT_COUNT     = 3;

    localparam logic [5:0] COL_ID    = 6'd0;
    localparam logic [5:0] COL_LEN   = 6'd1;
    localparam logic [5:0] COL_TYPE  = 6'd2;
    localparam logic [5:0] COL_CHECK = 6'd3;
    localparam logic [5:0] COL_CHAN  = 6'd4;
    localparam logic [5:0] COL_LINK  = 6'(4 + CHANNEL_COUNT);
    localparam logic [5:0] COL_ATT   = 6'(4 + CHANNEL_COUNT + LINK_COUNT);
    localparam logic [5:0] COL_FAIL  = 6'(4 + CHANNEL_COUNT + LINK_COUNT + ATT_COUNT);

    typedef enum logic [0:0] {
        CFG_SYNC   = 1'b0,
        CFG_MAXLEN = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        E_IDLE,
        E_RD,
        E_VAL,
        E_OUT
    } t_emit_state;

    typedef struct packed {
        logic       bank;
        logic [7:0] dev;
        logic [5:0] len;
        logic [7:0] ftype;
        logic [7:0] check;
        logic [31:0] fails;
    } t_frame_info;

    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] pos;
    } t_rd_req;

    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/rcfp_emit.sv =====
// Row emitter: reads a finished frame from the frame store and sends 34 columns.
// Depends on rcfp_pkg; the frame store read port lives in the top level.
module rcfp_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rcfp_pkg::t_frame_info i_info,
    output logic                 o_busy,
    output rcfp_pkg::t_rd_req    o_rd,
    input  logic [7:0]           i_rd_data,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [39:0]          o_m_tdata,  // [5:0] column, [37:6] column_value, [39:38] zero
    output logic                 o_m_tlast
);

    rcfp_pkg::t_emit_state r_state, n_state;
    rcfp_pkg::t_frame_info r_info;
    logic [5:0]  r_col;
    logic [1:0]  r_rk;
    logic        r_ok;
    logic [7:0]  r_win [0:2];
    logic [7:0]  r_link [0:rcfp_pkg::LINK_COUNT-1];
    logic [15:0] r_att [0:rcfp_pkg::ATT_COUNT-1];
    logic        r_ovalid;
    logic        r_olast;
    logic [5:0]  r_ocol;
    logic [31:0] r_oval;

    logic [5:0]  ci, li, ai;
    logic [7:0]  bitpos, p, pos;
    logic [1:0]  need;
    logic        in_chan, in_link, in_att, pos_ok;
    logic [23:0] chan_w;
    logic [10:0] chan;
    logic [31:0] value;

    always_comb begin
        ci      = r_col - rcfp_pkg::COL_CHAN;
        li      = r_col - rcfp_pkg::COL_LINK;
        ai      = r_col - rcfp_pkg::COL_ATT;
        bitpos  = {4'b0, ci[3:0]} * 8'd11;
        in_chan = (r_col >= rcfp_pkg::COL_CHAN) && (r_col < rcfp_pkg::COL_LINK);
        in_link = (r_col >= rcfp_pkg::COL_LINK) && (r_col < rcfp_pkg::COL_ATT);
        in_att  = (r_col >= rcfp_pkg::COL_ATT) && (r_col < rcfp_pkg::COL_FAIL);
        need    = 2'd0;
        p       = 8'd0;
        if (in_chan && r_info.ftype == rcfp_pkg::TYPE_CHANNELS) begin
            need = 2'd3;
            p    = bitpos >> 3;
        end else if (in_link && r_info.ftype == rcfp_pkg::TYPE_LINK) begin
            need = 2'd1;
            p    = {2'b0, li};
        end else if (in_att && r_info.ftype == rcfp_pkg::TYPE_ATTITUDE) begin
            need = 2'd2;
            p    = {1'b0, ai, 1'b0};
        end
        pos     = p + {6'b0, r_rk} + 8'd1;
        pos_ok  = ({1'b0, pos} + 9'd1) < {3'b0, r_info.len};
        o_rd.en   = (r_state == rcfp_pkg::E_RD) && (r_rk < need);
        o_rd.bank = r_info.bank;
        o_rd.pos  = pos;
    end

    always_comb begin
        chan_w = {r_win[2], r_win[1], r_win[0]};
        chan   = 11'(chan_w >> bitpos[2:0]);
        priority if (r_col == rcfp_pkg::COL_ID) begin
            value = {24'b0, r_info.dev};
        end else if (r_col == rcfp_pkg::COL_LEN) begin
            value = {26'b0, r_info.len};
        end else if (r_col == rcfp_pkg::COL_TYPE) begin
            value = {24'b0, r_info.ftype};
        end else if (r_col == rcfp_pkg::COL_CHECK) begin
            value = {24'b0, r_info.check};
        end else if (in_chan) begin
            value = (r_info.ftype == rcfp_pkg::TYPE_CHANNELS) ? {21'b0, chan} : 32'd0;
        end else if (in_link) begin
            value = {24'b0, (r_info.ftype == rcfp_pkg::TYPE_LINK) ? r_win[0]
                                                                 : r_link[li[3:0]]};
        end else if (in_att) begin
            value = {16'b0, (r_info.ftype == rcfp_pkg::TYPE_ATTITUDE) ? {r_win[1], r_win[0]}
                                                                      : r_att[ai[1:0]]};
        end else begin
            value = r_info.fails;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcfp_pkg::E_IDLE: begin
                if (i_start) n_state = rcfp_pkg::E_RD;
            end
            rcfp_pkg::E_RD: begin
                if (r_rk == need) n_state = rcfp_pkg::E_VAL;
            end
            rcfp_pkg::E_VAL: begin
                n_state = rcfp_pkg::E_OUT;
            end
            rcfp_pkg::E_OUT: begin
                if (i_m_tready) begin
                    n_state = (r_col == rcfp_pkg::COL_FAIL) ? rcfp_pkg::E_IDLE : rcfp_pkg::E_RD;
                end
            end
            default: n_state = rcfp_pkg::E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rcfp_pkg::E_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < rcfp_pkg::LINK_COUNT; i++) r_link[i] <= 8'd0;
            for (int i = 0; i < rcfp_pkg::ATT_COUNT; i++) r_att[i] <= 16'd0;
        end else begin
            r_state <= n_state;
            if (r_state == rcfp_pkg::E_VAL) begin
                r_ovalid <= 1'b1;
                if (in_link && r_info.ftype == rcfp_pkg::TYPE_LINK) begin
                    r_link[li[3:0]] <= r_win[0];
                end
                if (in_att && r_info.ftype == rcfp_pkg::TYPE_ATTITUDE) begin
                    r_att[ai[1:0]] <= {r_win[1], r_win[0]};
                end
            end else if (r_state == rcfp_pkg::E_OUT && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rcfp_pkg::E_IDLE: begin
                if (i_start) begin
                    r_info <= i_info;
                    r_col  <= 6'd0;
                    r_rk   <= 2'd0;
                end
            end
            rcfp_pkg::E_RD: begin
                r_rk <= r_rk + 2'd1;
                r_ok <= pos_ok;
                if (r_rk != 2'd0) r_win[r_rk - 2'd1] <= r_ok ? i_rd_data : 8'd0;
            end
            rcfp_pkg::E_VAL: begin
                r_ocol  <= r_col;
                r_oval  <= value;
                r_olast <= (r_col == rcfp_pkg::COL_FAIL);
            end
            rcfp_pkg::E_OUT: begin
                if (i_m_tready) begin
                    r_col <= r_col + 6'd1;
                    r_rk  <= 2'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_busy     = (r_state != rcfp_pkg::E_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b0, r_oval, r_ocol};
    assign o_m_tlast  = r_olast;

endmodule

// ===== hdl/radio_control_frame_parser_top.sv =====
// Top level: sync hunt, length check, CRC-8 and the double-banked frame store.
// Depends on rcfp_pkg, rcfp_emit and radio_control_frame_parser_top_defines.svh.
// Input takes one byte per cycle; it stalls only on a check byte while a row is still out.
// A row of 34 columns starts once its check byte is taken; each column goes through E_RD
// (frame store reads), E_VAL and E_OUT. Reset is synchronous and active low; it clears
// the parser registers and FSM states but not the frame store; no clearing pass is needed.
`include "radio_control_frame_parser_top_defines.svh"
module radio_control_frame_parser_top #(
    parameter int FRAME_STORE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [5:0] column, [37:6] column_value, [39:38] zero
    output logic        o_m_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(FRAME_STORE_DEPTH);

    logic [7:0]  r_sync;
    logic [5:0]  r_maxlen;
    rcfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_dev;
    logic [5:0]  r_len;
    logic [5:0]  r_cnt;
    logic [7:0]  r_crc;
    logic [7:0]  r_type;
    logic        r_bank;
    logic [31:0] r_fails;
    logic [7:0]  mem [0:(2 << AW)-1];
    logic [7:0]  r_rd_data;
    logic        r_rd_in_range;

    logic [7:0]  b, idx8;
    logic        accept, last_byte, crc_ok, att_skip, start, emit_busy, len_bad;
    rcfp_pkg::t_frame_info info;
    rcfp_pkg::t_rd_req     rd;

    assign o_cfg_ready = 1'b1;
    assign b           = i_s_tdata;
    assign idx8        = {2'b0, r_cnt};
    assign accept      = i_s_tvalid && o_s_tready;
    assign last_byte   = (r_phase == rcfp_pkg::PH_BODY) &&
                         (({1'b0, r_cnt} + 7'd1) == {1'b0, r_len});
    assign o_s_tready  = !(last_byte && emit_busy);
    assign crc_ok      = (r_crc == b);
    assign att_skip    = (r_type == rcfp_pkg::TYPE_ATTITUDE) && (r_len != rcfp_pkg::ATT_LEN);
    assign start       = accept && last_byte && crc_ok && !att_skip;
    assign len_bad     = (b < 8'd2) || (b > {2'b0, r_maxlen});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= rcfp_pkg::SYNC_RESET;
            r_maxlen <= rcfp_pkg::MAXLEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (rcfp_pkg::t_cfg_reg'(i_cfg_index))
                rcfp_pkg::CFG_SYNC:   r_sync   <= i_cfg_data;
                rcfp_pkg::CFG_MAXLEN: r_maxlen <= i_cfg_data[5:0];
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                rcfp_pkg::PH_LEN: begin
                    n_phase = len_bad ? rcfp_pkg::PH_HUNT : rcfp_pkg::PH_BODY;
                end
                rcfp_pkg::PH_BODY: begin
                    if (last_byte) n_phase = rcfp_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = (b == r_sync) ? rcfp_pkg::PH_LEN : rcfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rcfp_pkg::PH_HUNT;
            r_dev   <= 8'd0;
            r_len   <= 6'd0;
            r_cnt   <= 6'd0;
            r_crc   <= 8'd0;
            r_type  <= 8'd0;
            r_bank  <= 1'b0;
            r_fails <= 32'd0;
        end else begin
            r_phase <= n_phase;
            if (accept) begin
                unique case (r_phase)
                    rcfp_pkg::PH_LEN: begin
                        if (!len_bad) begin
                            r_len <= b[5:0];
                            r_cnt <= 6'd0;
                            r_crc <= 8'd0;
                        end
                    end
                    rcfp_pkg::PH_BODY: begin
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd0) r_type <= b;
                        if (!last_byte) begin
                            r_crc <= rcfp_pkg::crc_step(r_crc, b);
                        end else if (!crc_ok && r_fails != 32'hFFFF_FFFF) begin
                            r_fails <= r_fails + 32'd1;
                        end
                        if (start) r_bank <= ~r_bank;
                    end
                    default: begin
                        if (b == r_sync) r_dev <= b;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_phase == rcfp_pkg::PH_BODY && 32'(idx8) < FRAME_STORE_DEPTH) begin
            mem[{r_bank, idx8[AW-1:0]}] <= b;
        end
        if (rd.en) begin
            r_rd_data     <= mem[{rd.bank, rd.pos[AW-1:0]}];
            r_rd_in_range <= 32'(rd.pos) < FRAME_STORE_DEPTH;
        end
    end

    always_comb begin
        info.bank  = r_bank;
        info.dev   = r_dev;
        info.len   = r_len;
        info.ftype = r_type;
        info.check = b;
        info.fails = r_fails;
    end

    rcfp_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_info     (info),
        .o_busy     (emit_busy),
        .o_rd       (rd),
        .i_rd_data  (r_rd_in_range ? r_rd_data : 8'd0),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    `RCFP_NEVER(a_start_when_busy, i_clk, i_rst_n, start && emit_busy)
    `RCFP_ASSERT(a_bank_flip, i_clk, i_rst_n, start |=> (r_bank != $past(r_bank)))
    `RCFP_ASSERT(a_last_col, i_clk, i_rst_n, (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[5:0] == rcfp_pkg::COL_FAIL))
    `RCFP_ASSERT(a_cnt_in_len, i_clk, i_rst_n, (r_phase == rcfp_pkg::PH_BODY) |-> (r_cnt < r_len))

endmodule
